// ===== rtl/core/scacc_pkg.sv =====
package scacc_pkg;

  localparam int DEF_PAIR_CAPACITY = 256;
  localparam int DEF_LEVEL_BITS    = 16;
  localparam int NUM_LISTS         = 5;
  localparam int NUM_AGG           = 4;
  localparam int COUNT_W           = 9;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  localparam logic [2:0] SEL_PAIR = 3'd0;
  localparam logic [2:0] SEL_SUM  = 3'd1;
  localparam logic [2:0] SEL_DIFF = 3'd2;
  localparam logic [2:0] SEL_REF  = 3'd3;
  localparam logic [2:0] SEL_NBR  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PSCAN,
    ST_PWRITE,
    ST_ASCAN,
    ST_AWRITE,
    ST_RDA,
    ST_RDB,
    ST_DONE
  } state_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    sat_inc = (c == COUNT_MAX) ? c : c + 9'd1;
  endfunction

endpackage

// ===== rtl/core/sparse_cooccurrence_accumulator_top.sv =====
// Sparse gray-level co-occurrence accumulator. Each request carries a command: clear all
// lists, insert a pixel pair, or read one entry of one of five lists (pairs, level sums,
// absolute differences, reference marginal, neighbor marginal). Every request gives exactly
// one result. All lists sit in single-port-read synchronous memories of PAIR_CAPACITY
// entries. An insert scans the pair list one entry a cycle and writes the pair entry back;
// unless the pair list is full and holds no match, it then scans the four derived lists
// side by side, one entry a cycle each, and writes them back. One request is in work at a
// time; the result waits in an output register while the next request is taken. No clearing
// pass is needed after reset. cfg_data sets symmetric mode; the user must write it only
// when idle, as the block itself does not enforce it.
module sparse_cooccurrence_accumulator_top #(
  parameter int PAIR_CAPACITY = scacc_pkg::DEF_PAIR_CAPACITY,
  parameter int LEVEL_BITS    = scacc_pkg::DEF_LEVEL_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_ref_level,
  input  logic [15:0] in_nbr_level,
  input  logic [2:0]  in_list_select,
  input  logic [7:0]  in_entry_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] out_entry_key_a,
  output logic [15:0] out_entry_key_b,
  output logic [8:0]  out_entry_count,
  output logic        out_entry_valid,
  output logic [8:0]  out_list_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  localparam int LB    = LEVEL_BITS;
  localparam int AW    = LEVEL_BITS + 1;
  localparam int CW    = scacc_pkg::COUNT_W;
  localparam int NA    = scacc_pkg::NUM_AGG;
  localparam int NL    = scacc_pkg::NUM_LISTS;
  localparam int IDX_W = (PAIR_CAPACITY > 1) ? $clog2(PAIR_CAPACITY) : 1;
  localparam int LEN_W = $clog2(PAIR_CAPACITY + 1);
  localparam int PW    = 2 * LB + CW;
  localparam int EW    = AW + CW;
  localparam logic [LEN_W-1:0] CAP_L = LEN_W'(PAIR_CAPACITY);

  logic [PW-1:0] pair_mem [PAIR_CAPACITY];
  logic [EW-1:0] agg_mem  [NA][PAIR_CAPACITY];
  logic [PW-1:0] pair_rd_r;
  logic [EW-1:0] agg_rd_r [NA];

  scacc_pkg::state_t state_r, state_nxt;
  logic             sym_r;
  logic [1:0]       cmd_r;
  logic [2:0]       sel_r;
  logic [7:0]       idx_r;
  logic [LB-1:0]    a_r, b_r, x_r, y_r;
  logic [LEN_W-1:0] p_r, pp_r, fidx_r;
  logic             chk_r, pfnd_r;
  logic [CW-1:0]    fcnt_r;
  logic [AW-1:0]    akey_r [NA];
  logic             achk_r [NA];
  logic             afnd_r [NA];
  logic [LEN_W-1:0] afi_r  [NA];
  logic [CW-1:0]    afc_r  [NA];
  logic [LEN_W-1:0] len_r  [NL];
  logic [AW-1:0]    res_ka_r;
  logic [LB-1:0]    res_kb_r;
  logic [CW-1:0]    res_cnt_r;
  logic             res_val_r;
  logic [LEN_W-1:0] res_len_r;
  logic             out_valid_r;
  logic [16:0]      out_ka_r;
  logic [15:0]      out_kb_r;
  logic [8:0]       out_cnt_r;
  logic             out_ev_r;
  logic [8:0]       out_len_r;

  logic [IDX_W-1:0] rd_addr;
  logic [LB-1:0]    pe_a, pe_b, lv_r, lv_n;
  logic [CW-1:0]    pe_c;
  logic [AW-1:0]    ae_key [NA];
  logic [CW-1:0]    ae_cnt [NA];
  logic             amatch [NA];
  logic             adone  [NA];
  logic             all_done, pmatch, pscan_end, accept, out_free, rd_ok;
  logic             pw_en;
  logic [IDX_W-1:0] pw_addr;
  logic [PW-1:0]    pw_data;
  logic             aw_en   [NA];
  logic [IDX_W-1:0] aw_addr [NA];
  logic [EW-1:0]    aw_data [NA];
  logic [1:0]       sel_m1;

  assign in_stall  = (state_r != scacc_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  assign out_valid       = out_valid_r;
  assign out_entry_key_a = out_ka_r;
  assign out_entry_key_b = out_kb_r;
  assign out_entry_count = out_cnt_r;
  assign out_entry_valid = out_ev_r;
  assign out_list_length = out_len_r;

  assign lv_r = LB'(in_ref_level);
  assign lv_n = LB'(in_nbr_level);

  assign pe_a = pair_rd_r[PW-1 -: LB];
  assign pe_b = pair_rd_r[LB+CW-1 -: LB];
  assign pe_c = pair_rd_r[CW-1:0];
  assign pmatch = chk_r && ((pe_a == a_r && pe_b == b_r) ||
                            (sym_r && pe_a == b_r && pe_b == a_r));
  assign pscan_end = !chk_r && (p_r >= len_r[0]);
  assign sel_m1 = 2'(sel_r - 3'd1);
  assign rd_ok  = (sel_r <= scacc_pkg::SEL_NBR) && (32'(idx_r) < 32'(len_r[sel_r]));

  always_comb begin
    all_done = 1'b1;
    for (int k = 0; k < NA; k++) begin
      ae_key[k] = agg_rd_r[k][EW-1:CW];
      ae_cnt[k] = agg_rd_r[k][CW-1:0];
      amatch[k] = achk_r[k] && !afnd_r[k] && (ae_key[k] == akey_r[k]);
      adone[k]  = afnd_r[k] || (!achk_r[k] && (p_r >= len_r[k+1]));
      all_done  = all_done && adone[k];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      scacc_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_cmd == scacc_pkg::CMD_INSERT) state_nxt = scacc_pkg::ST_PSCAN;
          else if (in_cmd == scacc_pkg::CMD_READ) state_nxt = scacc_pkg::ST_RDA;
          else state_nxt = scacc_pkg::ST_DONE;
        end
      end
      scacc_pkg::ST_PSCAN:  if (pmatch || pscan_end) state_nxt = scacc_pkg::ST_PWRITE;
      scacc_pkg::ST_PWRITE: begin
        if (pfnd_r || len_r[0] < CAP_L) state_nxt = scacc_pkg::ST_ASCAN;
        else state_nxt = scacc_pkg::ST_DONE;
      end
      scacc_pkg::ST_ASCAN:  if (all_done) state_nxt = scacc_pkg::ST_AWRITE;
      scacc_pkg::ST_AWRITE: state_nxt = scacc_pkg::ST_DONE;
      scacc_pkg::ST_RDA:    state_nxt = scacc_pkg::ST_RDB;
      scacc_pkg::ST_RDB:    state_nxt = scacc_pkg::ST_DONE;
      scacc_pkg::ST_DONE:   if (out_free) state_nxt = scacc_pkg::ST_IDLE;
      default:              state_nxt = scacc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rd_addr = p_r[IDX_W-1:0];
    pw_en   = 1'b0;
    pw_addr = pfnd_r ? fidx_r[IDX_W-1:0] : len_r[0][IDX_W-1:0];
    pw_data = pfnd_r ? {x_r, y_r, scacc_pkg::sat_inc(fcnt_r)} : {a_r, b_r, CW'(1)};
    for (int k = 0; k < NA; k++) begin
      aw_en[k]   = 1'b0;
      aw_addr[k] = afnd_r[k] ? afi_r[k][IDX_W-1:0] : len_r[k+1][IDX_W-1:0];
      aw_data[k] = afnd_r[k] ? {akey_r[k], scacc_pkg::sat_inc(afc_r[k])}
                             : {akey_r[k], CW'(1)};
    end
    case (state_r)
      scacc_pkg::ST_RDA:    rd_addr = IDX_W'(idx_r);
      scacc_pkg::ST_PWRITE: pw_en = pfnd_r || (len_r[0] < CAP_L);
      scacc_pkg::ST_AWRITE: begin
        for (int k = 0; k < NA; k++) aw_en[k] = afnd_r[k] || (len_r[k+1] < CAP_L);
      end
      default: rd_addr = p_r[IDX_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    pair_rd_r <= pair_mem[rd_addr];
    if (pw_en) pair_mem[pw_addr] <= pw_data;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NA; k++) begin
      agg_rd_r[k] <= agg_mem[k][rd_addr];
      if (aw_en[k]) agg_mem[k][aw_addr[k]] <= aw_data[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= scacc_pkg::ST_IDLE;
      sym_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NL; k++) len_r[k] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) sym_r <= cfg_data;
      if (state_r == scacc_pkg::ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        scacc_pkg::ST_IDLE: begin
          if (accept && in_cmd == scacc_pkg::CMD_CLEAR) begin
            for (int k = 0; k < NL; k++) len_r[k] <= '0;
          end
        end
        scacc_pkg::ST_PWRITE: begin
          if (!pfnd_r && len_r[0] < CAP_L) len_r[0] <= len_r[0] + 1'b1;
        end
        scacc_pkg::ST_AWRITE: begin
          for (int k = 0; k < NA; k++) begin
            if (!afnd_r[k] && len_r[k+1] < CAP_L) len_r[k+1] <= len_r[k+1] + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      scacc_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_r     <= in_cmd;
          sel_r     <= in_list_select;
          idx_r     <= in_entry_index;
          a_r       <= (sym_r && lv_n > lv_r) ? lv_n : lv_r;
          b_r       <= (sym_r && lv_n > lv_r) ? lv_r : lv_n;
          p_r       <= '0;
          chk_r     <= 1'b0;
          res_ka_r  <= '0;
          res_kb_r  <= '0;
          res_cnt_r <= '0;
          res_val_r <= 1'b0;
          res_len_r <= '0;
        end
      end
      scacc_pkg::ST_PSCAN: begin
        chk_r <= p_r < len_r[0];
        pp_r  <= p_r;
        if (p_r < CAP_L) p_r <= p_r + 1'b1;
        pfnd_r <= pmatch;
        fidx_r <= pp_r;
        fcnt_r <= pe_c;
        x_r    <= pmatch ? pe_a : a_r;
        y_r    <= pmatch ? pe_b : b_r;
      end
      scacc_pkg::ST_PWRITE: begin
        fcnt_r    <= pfnd_r ? scacc_pkg::sat_inc(fcnt_r) : CW'(1);
        res_len_r <= len_r[0];
        akey_r[0] <= AW'(x_r) + AW'(y_r);
        akey_r[1] <= (x_r > y_r) ? AW'(x_r - y_r) : AW'(y_r - x_r);
        akey_r[2] <= AW'(x_r);
        akey_r[3] <= AW'(y_r);
        p_r <= '0;
        for (int k = 0; k < NA; k++) begin
          achk_r[k] <= 1'b0;
          afnd_r[k] <= 1'b0;
        end
      end
      scacc_pkg::ST_ASCAN: begin
        pp_r <= p_r;
        if (p_r < CAP_L) p_r <= p_r + 1'b1;
        for (int k = 0; k < NA; k++) begin
          achk_r[k] <= p_r < len_r[k+1];
          if (amatch[k]) begin
            afnd_r[k] <= 1'b1;
            afi_r[k]  <= pp_r;
            afc_r[k]  <= ae_cnt[k];
          end
        end
      end
      scacc_pkg::ST_AWRITE: begin
        res_ka_r  <= AW'(x_r);
        res_kb_r  <= y_r;
        res_cnt_r <= fcnt_r;
        res_val_r <= 1'b1;
        res_len_r <= len_r[0];
      end
      scacc_pkg::ST_RDB: begin
        if (sel_r <= scacc_pkg::SEL_NBR) res_len_r <= len_r[sel_r];
        if (rd_ok) begin
          res_val_r <= 1'b1;
          if (sel_r == scacc_pkg::SEL_PAIR) begin
            res_ka_r  <= AW'(pe_a);
            res_kb_r  <= pe_b;
            res_cnt_r <= pe_c;
          end else begin
            res_ka_r  <= ae_key[sel_m1];
            res_cnt_r <= ae_cnt[sel_m1];
          end
        end
      end
      scacc_pkg::ST_DONE: begin
        if (out_free) begin
          out_ka_r  <= 17'(res_ka_r);
          out_kb_r  <= 16'(res_kb_r);
          out_cnt_r <= res_cnt_r;
          out_ev_r  <= res_val_r && (cmd_r != scacc_pkg::CMD_CLEAR);
          out_len_r <= 9'(res_len_r);
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== tb/cooc_checker.sv =====
`timescale 1ns / 100ps

module cooc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_ref_level,
  input  logic [15:0] in_nbr_level,
  input  logic [2:0]  in_list_select,
  input  logic [7:0]  in_entry_index,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [16:0] out_entry_key_a,
  input  logic [15:0] out_entry_key_b,
  input  logic [8:0]  out_entry_count,
  input  logic        out_entry_valid,
  input  logic [8:0]  out_list_length,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_data,
  output int          errors,
  output int          outstanding
);

  localparam int CAP = scacc_pkg::DEF_PAIR_CAPACITY;
  localparam int NLS = scacc_pkg::NUM_LISTS;

  typedef struct packed {
    logic [16:0] key_a;
    logic [15:0] key_b;
    logic [8:0]  count;
    logic        valid;
    logic [8:0]  length;
  } entry_rd_t;

  entry_rd_t   result_q[$];
  logic [16:0] list_key[NLS][CAP];
  logic [15:0] pair_key_b[CAP];
  logic [8:0]  list_cnt[NLS][CAP];
  int          list_len[NLS];
  logic        sym_mode;

  function automatic logic [8:0] bump(input logic [8:0] c);
    return (c == scacc_pkg::COUNT_MAX) ? c : c + 9'd1;
  endfunction

  function automatic void tally(input logic [2:0] sel, input logic [16:0] key);
    int p;
    for (p = 0; p < list_len[sel]; p++) begin
      if (list_key[sel][p] == key) begin
        list_cnt[sel][p] = bump(list_cnt[sel][p]);
        return;
      end
    end
    if (list_len[sel] < CAP) begin
      list_key[sel][list_len[sel]] = key;
      list_cnt[sel][list_len[sel]] = 9'd1;
      list_len[sel]++;
    end
  endfunction

  function automatic entry_rd_t accumulate(input logic [1:0] cmd, input logic [15:0] r,
                                           input logic [15:0] n, input logic [2:0] sel,
                                           input logic [7:0] idx);
    entry_rd_t   res;
    logic [15:0] a, b, x, y;
    int          p;
    bit          hit;
    res = '0;
    if (cmd == scacc_pkg::CMD_CLEAR) begin
      for (p = 0; p < NLS; p++) list_len[p] = 0;
    end else if (cmd == scacc_pkg::CMD_INSERT) begin
      a = r;
      b = n;
      hit = 0;
      if (sym_mode && n > r) begin
        a = n;
        b = r;
      end
      for (p = 0; p < list_len[scacc_pkg::SEL_PAIR]; p++) begin
        if ((list_key[scacc_pkg::SEL_PAIR][p][15:0] == a && pair_key_b[p] == b) ||
            (sym_mode && list_key[scacc_pkg::SEL_PAIR][p][15:0] == b &&
             pair_key_b[p] == a)) begin
          hit = 1;
          break;
        end
      end
      if (!hit && list_len[scacc_pkg::SEL_PAIR] < CAP) begin
        p = list_len[scacc_pkg::SEL_PAIR];
        list_key[scacc_pkg::SEL_PAIR][p] = {1'b0, a};
        pair_key_b[p] = b;
        list_cnt[scacc_pkg::SEL_PAIR][p] = 9'd0;
        list_len[scacc_pkg::SEL_PAIR]++;
        hit = 1;
      end
      if (hit) begin
        x = list_key[scacc_pkg::SEL_PAIR][p][15:0];
        y = pair_key_b[p];
        list_cnt[scacc_pkg::SEL_PAIR][p] = bump(list_cnt[scacc_pkg::SEL_PAIR][p]);
        tally(scacc_pkg::SEL_SUM, {1'b0, x} + {1'b0, y});
        tally(scacc_pkg::SEL_DIFF, {1'b0, (x > y) ? x - y : y - x});
        tally(scacc_pkg::SEL_REF, {1'b0, x});
        tally(scacc_pkg::SEL_NBR, {1'b0, y});
        res.key_a = {1'b0, x};
        res.key_b = y;
        res.count = list_cnt[scacc_pkg::SEL_PAIR][p];
        res.valid = 1'b1;
      end
      res.length = list_len[scacc_pkg::SEL_PAIR][8:0];
    end else if (cmd == scacc_pkg::CMD_READ && sel <= scacc_pkg::SEL_NBR) begin
      res.length = list_len[sel][8:0];
      if (idx < list_len[sel]) begin
        res.key_a = list_key[sel][idx];
        res.key_b = (sel == scacc_pkg::SEL_PAIR) ? pair_key_b[idx] : 16'd0;
        res.count = list_cnt[sel][idx];
        res.valid = 1'b1;
      end
    end
    return res;
  endfunction

  entry_rd_t got, want;

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NLS; i++) list_len[i] = 0;
      sym_mode = 1'b0;
      result_q.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) sym_mode = cfg_data;
      if (in_valid && !in_stall)
        result_q.push_back(accumulate(in_cmd, in_ref_level, in_nbr_level,
                                      in_list_select, in_entry_index));
      if (out_valid && !out_stall) begin
        got = {out_entry_key_a, out_entry_key_b, out_entry_count, out_entry_valid,
               out_list_length};
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          want = result_q.pop_front();
          if (got.key_a !== want.key_a) begin
            $display("%0t: key_a exp %h got %h", $time, want.key_a, got.key_a);
            errors++;
          end
          if (got.key_b !== want.key_b) begin
            $display("%0t: key_b exp %h got %h", $time, want.key_b, got.key_b);
            errors++;
          end
          if (got.count !== want.count) begin
            $display("%0t: count exp %0d got %0d", $time, want.count, got.count);
            errors++;
          end
          if (got.valid !== want.valid) begin
            $display("%0t: entry_valid exp %b got %b", $time, want.valid, got.valid);
            errors++;
          end
          if (got.length !== want.length) begin
            $display("%0t: length exp %0d got %0d", $time, want.length, got.length);
            errors++;
          end
        end
      end
    end
    outstanding = result_q.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int LIMIT = 4000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd = scacc_pkg::CMD_CLEAR;
  logic [15:0] in_ref_level = '0;
  logic [15:0] in_nbr_level = '0;
  logic [2:0]  in_list_select = scacc_pkg::SEL_PAIR;
  logic [7:0]  in_entry_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [16:0] out_entry_key_a;
  logic [15:0] out_entry_key_b;
  logic [8:0]  out_entry_count;
  logic        out_entry_valid;
  logic [8:0]  out_list_length;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;
  int          errors;
  int          outstanding;
  int          cycles = 0;
  int          stall_left = 0;
  bit          quiet = 0;

  sparse_cooccurrence_accumulator_top DUT (.*);
  cooc_checker u_checker (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (quiet || r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      stall_left <= pick_gap();
      out_stall <= 1'b0;
    end
  end

  task automatic send(input logic [1:0] cmd, input logic [15:0] r, input logic [15:0] n,
                      input logic [2:0] sel, input logic [7:0] idx);
    int gap;
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_ref_level <= r;
    in_nbr_level <= n;
    in_list_select <= sel;
    in_entry_index <= idx;
    do @(posedge clk); while (in_stall);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_mode(input logic v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_all(input logic [7:0] idx);
    for (int s = 0; s <= scacc_pkg::SEL_NBR; s++)
      send(scacc_pkg::CMD_READ, '0, '0, s[2:0], idx);
  endtask

  logic [15:0] ra, na;
  int          r;

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(scacc_pkg::CMD_INSERT, 16'd0, 16'd0, scacc_pkg::SEL_PAIR, 8'd0);
    send(scacc_pkg::CMD_INSERT, 16'hFFFF, 16'hFFFF, 3'd7, 8'hFF);
    send(scacc_pkg::CMD_INSERT, 16'hFFFF, 16'd0, scacc_pkg::SEL_PAIR, 8'd0);
    send(scacc_pkg::CMD_INSERT, 16'd3, 16'd5, scacc_pkg::SEL_PAIR, 8'd0);
    send(scacc_pkg::CMD_INSERT, 16'd5, 16'd3, scacc_pkg::SEL_PAIR, 8'd0);
    read_all(8'd0);
    read_all(8'd2);
    send(scacc_pkg::CMD_READ, '0, '0, scacc_pkg::SEL_PAIR, 8'hFF);
    send(scacc_pkg::CMD_READ, '0, '0, 3'd5, 8'd0);
    send(scacc_pkg::CMD_READ, '0, '0, 3'd7, 8'd0);
    send(scacc_pkg::CMD_NOP, 16'hFFFF, 16'hFFFF, 3'd7, 8'hFF);
    send(scacc_pkg::CMD_CLEAR, 16'hFFFF, 16'hFFFF, 3'd7, 8'hFF);
    send(scacc_pkg::CMD_READ, '0, '0, scacc_pkg::SEL_PAIR, 8'd0);

    send(scacc_pkg::CMD_INSERT, 16'd2, 16'd9, scacc_pkg::SEL_PAIR, 8'd0);
    set_mode(1'b1);
    send(scacc_pkg::CMD_INSERT, 16'd9, 16'd2, scacc_pkg::SEL_PAIR, 8'd0);
    send(scacc_pkg::CMD_INSERT, 16'd3, 16'd5, scacc_pkg::SEL_PAIR, 8'd0);
    send(scacc_pkg::CMD_INSERT, 16'd5, 16'd3, scacc_pkg::SEL_PAIR, 8'd0);
    read_all(8'd1);

    set_mode(1'b0);
    quiet = 1;
    send(scacc_pkg::CMD_CLEAR, '0, '0, scacc_pkg::SEL_PAIR, 8'd0);
    repeat (520) send(scacc_pkg::CMD_INSERT, 16'd7, 16'd7, scacc_pkg::SEL_PAIR, 8'd0);
    read_all(8'd0);
    quiet = 0;

    set_mode(1'b1);
    send(scacc_pkg::CMD_CLEAR, '0, '0, scacc_pkg::SEL_PAIR, 8'd0);
    for (int i = 0; i < 262; i++)
      send(scacc_pkg::CMD_INSERT, i[15:0], i[15:0] + 16'd1000, scacc_pkg::SEL_PAIR, 8'd0);
    send(scacc_pkg::CMD_INSERT, 16'd1000, 16'd0, scacc_pkg::SEL_PAIR, 8'd0);
    read_all(8'hFF);
    read_all(8'd128);

    for (int k = 0; k < 70; k++) begin
      if (k % 14 == 0) begin
        set_mode(1'($urandom_range(0, 1)));
        quiet = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 7) == 0) begin
        ra = 16'($urandom);
        na = 16'($urandom);
      end else begin
        ra = 16'($urandom_range(0, 7));
        na = 16'($urandom_range(0, 7));
      end
      if (r < 60)
        send(scacc_pkg::CMD_INSERT, ra, na, 3'($urandom), 8'($urandom));
      else if (r < 94)
        send(scacc_pkg::CMD_READ, ra, na, ($urandom_range(0, 9) == 0) ?
             3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4)),
             ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20)));
      else if (r < 97)
        send(scacc_pkg::CMD_CLEAR, ra, na, 3'($urandom), 8'($urandom));
      else
        send(scacc_pkg::CMD_NOP, ra, na, 3'($urandom), 8'($urandom));
    end

    drain();
    if (errors == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/scacc_pkg.sv
rtl/core/sparse_cooccurrence_accumulator_top.sv
tb/cooc_checker.sv
tb/tb.sv
